// ===== hdl/cos_pkg.sv =====
// ----------------------------------------------------------------------------
// cos_pkg
// Types, constants and saturating helpers for the clock offset smoother.
// ----------------------------------------------------------------------------
package cos_pkg;

    localparam int TIME_FRAC_BITS = 32;
    localparam int FREQ_FRAC_BITS = 48;
    localparam int SH_TIME        = TIME_FRAC_BITS;
    localparam int SH_FREQ        = FREQ_FRAC_BITS;
    localparam int SH_HALF        = FREQ_FRAC_BITS + 1;
    localparam int SH_S1          = TIME_FRAC_BITS + FREQ_FRAC_BITS;

    localparam int IN_DATA_W  = 232;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 1;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 49;

    typedef logic signed [63:0] t_s64;
    typedef logic [63:0]        t_u64;
    typedef logic [127:0]       t_u128;

    localparam t_s64 S64_MAX = {1'b0, {63{1'b1}}};
    localparam t_s64 S64_MIN = {1'b1, 63'b0};
    localparam t_s64 ONE_FREQ = t_s64'(64'd1 << FREQ_FRAC_BITS);

    localparam logic [13:0] LOCK_RATIO = 14'd10000;

    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_FREQUENCY   = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_WANDER_RATE = 1'b1;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_ADJUST = 2'd1,
        OP_CHANGE = 2'd2,
        OP_RESET  = 2'd3
    } t_opcode;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISP,
        S_WAIT,
        S_INT0,
        S_INT_LOOP,
        S_INT_WL,
        S_INT_OFF,
        S_INT_TAIL,
        S_INT_END,
        S_EMIT,
        S_ADJ1,
        S_ADJ2,
        S_RB0,
        S_RB1,
        S_RB2,
        S_RB3,
        S_RB_TRY,
        S_RB_L,
        S_RB_D,
        S_RB_E,
        S_RB_G,
        S_RB_G2,
        S_RB_H,
        S_RB_FIN,
        S_SH0,
        S_SH1
    } t_state;

    function automatic t_s64 sadd(t_s64 a, t_s64 b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic t_s64 ssub(t_s64 a, t_s64 b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic t_u64 mag(t_s64 a);
        return a[63] ? t_u64'(-a) : t_u64'(a);
    endfunction

    function automatic t_s64 from_mag(logic neg, t_u64 m);
        if (!neg) begin
            return m[63] ? S64_MAX : t_s64'(m);
        end
        return m[63] ? S64_MIN : -t_s64'(m);
    endfunction

    function automatic t_u64 u64sat(t_u128 x);
        return (|x[127:64]) ? {64{1'b1}} : x[63:0];
    endfunction

    function automatic t_u128 shl_sat(t_u64 m, int sh);
        t_u128 x;
        x = {64'b0, m};
        if (sh == 0 || m == '0) begin
            return x;
        end
        if ((x >> (128 - sh)) != '0) begin
            return {128{1'b1}};
        end
        return x << sh;
    endfunction

    function automatic t_u128 add_sat128(t_u128 a, t_u128 b);
        logic [128:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[128] ? {128{1'b1}} : s[127:0];
    endfunction

    function automatic t_s64 mulsh_res(t_u128 p, int sh, logic neg);
        return from_mag(neg, u64sat(p >> sh));
    endfunction

    function automatic t_s64 divsh_res(t_u128 q, logic neg, logic bz, logic az, logic aneg);
        if (bz) begin
            if (az) begin
                return '0;
            end
            return aneg ? S64_MIN : S64_MAX;
        end
        return from_mag(neg, u64sat(q));
    endfunction

endpackage

// ===== hdl/cos_mul.sv =====
// ----------------------------------------------------------------------------
// cos_mul
// Shift-add 64 x 64 unsigned multiplier, one bit per cycle.
// ----------------------------------------------------------------------------
module cos_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  cos_pkg::t_u64  i_a,
    input  cos_pkg::t_u64  i_b,
    output logic           o_busy,
    output cos_pkg::t_u128 o_prod
);
    import cos_pkg::*;

    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    t_u64        r_a, n_a;
    t_u128       r_p, n_p;
    logic [64:0] w_sum;

    always_comb begin
        w_sum  = {1'b0, r_p[127:64]} + (r_p[0] ? {1'b0, r_a} : 65'd0);
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_p    = r_p;
        if (i_go) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_a    = i_a;
            n_p    = {64'b0, i_b};
        end else if (r_busy) begin
            n_p   = {w_sum, r_p[63:1]};
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_a   <= n_a;
        r_p   <= n_p;
    end

    assign o_busy = r_busy;
    assign o_prod = r_p;

endmodule

// ===== hdl/cos_div.sv =====
// ----------------------------------------------------------------------------
// cos_div
// Restoring 128 / 64 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cos_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  cos_pkg::t_u128 i_num,
    input  cos_pkg::t_u64  i_den,
    output logic           o_busy,
    output cos_pkg::t_u128 o_quot
);
    import cos_pkg::*;

    logic       r_busy, n_busy;
    logic [6:0] r_cnt, n_cnt;
    t_u128      r_x, n_x;
    t_u64       r_rem, n_rem;
    t_u64       r_d, n_d;
    t_u64       w_rem2;
    logic       w_ge;

    always_comb begin
        w_rem2 = {r_rem[62:0], r_x[127]};
        w_ge   = r_rem[63] || (w_rem2 >= r_d);
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_x    = r_x;
        n_rem  = r_rem;
        n_d    = r_d;
        if (i_go) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_x    = i_num;
            n_rem  = '0;
            n_d    = i_den;
        end else if (r_busy) begin
            n_rem = w_ge ? (w_rem2 - r_d) : w_rem2;
            n_x   = {r_x[126:0], w_ge};
            n_cnt = r_cnt + 7'd1;
            if (r_cnt == 7'd127) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_x   <= n_x;
        r_rem <= n_rem;
        r_d   <= n_d;
    end

    assign o_busy = r_busy;
    assign o_quot = r_x;

endmodule

// ===== hdl/cos_sqrt.sv =====
// ----------------------------------------------------------------------------
// cos_sqrt
// Digit-by-digit integer square root of a 128-bit value, one bit per cycle.
// ----------------------------------------------------------------------------
module cos_sqrt (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_go,
    input  cos_pkg::t_u128 i_x,
    output logic           o_busy,
    output cos_pkg::t_u64  o_root
);
    import cos_pkg::*;

    logic        r_busy, n_busy;
    logic [5:0]  r_cnt, n_cnt;
    t_u128       r_x, n_x;
    logic [66:0] r_rem, n_rem;
    t_u64        r_root, n_root;
    logic [66:0] w_rem2;
    logic [66:0] w_trial;
    logic        w_ge;

    always_comb begin
        w_rem2  = {r_rem[64:0], r_x[127:126]};
        w_trial = {1'b0, r_root, 2'b01};
        w_ge    = w_rem2 >= w_trial;
        n_busy  = r_busy;
        n_cnt   = r_cnt;
        n_x     = r_x;
        n_rem   = r_rem;
        n_root  = r_root;
        if (i_go) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_x    = i_x;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rem  = w_ge ? (w_rem2 - w_trial) : w_rem2;
            n_root = {r_root[62:0], w_ge};
            n_x    = {r_x[125:0], 2'b00};
            n_cnt  = r_cnt + 6'd1;
            if (r_cnt == 6'd63) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_x    <= n_x;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ===== hdl/clock_offset_smoother_core.sv =====
// ----------------------------------------------------------------------------
// clock_offset_smoother_core
// Clock offset smoother: integrates and rebuilds a three-stage wander profile
// with a sequencer driving shared multiplier, divider and square-root units.
//
// channel   dir  fields (lsb first)
// s_axis    in   tdata: now_time, offset_change, freq_change, clock_skew
//                tuser: opcode
// m_axis    out  tdata: smoothed_offset; tuser: is_enabled
// cfg       in   i_cfg_we / i_cfg_addr / i_cfg_data, one register per write
//
// One item at a time; s_axis_tready is high only while idle.
// Query: up to 7 multiplies. Disabled adjusts, changes and resets return to
// idle from dispatch, a disabled query goes straight to emit, and a locked
// adjust does one multiply. A pending result in the output register is held
// while the next item is taken.
// Reset is synchronous; no clearing pass.
// ----------------------------------------------------------------------------
module clock_offset_smoother_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // now_time[63:0], offset_change[127:64], freq_change[175:128],
    // clock_skew[224:176], zero pad
    input  logic [cos_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // opcode[1:0]
    input  logic [cos_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // smoothed_offset[63:0]
    output logic [cos_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // is_enabled[0]
    output logic [cos_pkg::OUT_USER_W-1:0]    m_axis_tuser,
    input  logic                              i_cfg_we,
    input  logic [cos_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [cos_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import cos_pkg::*;

    t_state      r_state, n_state, r_ret, n_ret;
    logic [48:0] r_mf, n_mf, r_mw, n_mw;
    t_s64        r_ho, n_ho, r_hf, n_hf, r_lut, n_lut;
    t_s64        r_len [3];
    t_s64        n_len [3];
    logic        r_dir, n_dir, r_locked, n_locked;

    t_opcode     r_op, n_op;
    t_s64        r_now, n_now, r_doff, n_doff, r_dfreq, n_dfreq;
    logic [48:0] r_skew, n_skew;

    t_s64        r_el, n_el, r_off, n_off, r_fr, n_fr, r_lcur, n_lcur, r_wl, n_wl;
    t_s64        r_q, n_q, r_l1, n_l1, r_l2, n_l2, r_l3, n_l3;
    t_s64        r_dirfr, n_dirfr, r_f, n_f, r_lc, n_lc, r_f2, n_f2;
    t_u128       r_s1, n_s1, r_s2, n_s2;
    logic [1:0]  r_i, n_i;
    logic        r_try, n_try, r_found, n_found, r_rdir, n_rdir, r_msign, n_msign;
    logic        r_dneg, n_dneg, r_dbz, n_dbz, r_daz, n_daz, r_daneg, n_daneg;

    logic        r_ovalid, n_ovalid, r_oen, n_oen;
    t_s64        r_odata, n_odata;

    logic        mul_go, mul_busy, div_go, div_busy, sqrt_go, sqrt_busy;
    t_u64        mul_a, mul_b, div_den, sqrt_root;
    t_u128       mul_prod, div_num, div_quot, sqrt_x;

    logic        en, el_pos, s1_neg, s1_zero, s2_ge, f_pos, lc_over, f2_sel_pos, f2_pos;
    logic        found_dir;
    t_s64        mw_s, mf_s, mres32, mres48, mres49, dres, sqrt_l3, sqrt_l1;
    t_s64        f_calc, f2_sel, lcur_sel;
    logic [62:0] lock_limit;

    cos_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (mul_go),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_prod  (mul_prod)
    );

    cos_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (div_go),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    cos_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (sqrt_go),
        .i_x     (sqrt_x),
        .o_busy  (sqrt_busy),
        .o_root  (sqrt_root)
    );

    assign en         = (r_mf != '0) && (r_mw != '0);
    assign mw_s       = t_s64'({15'b0, r_mw});
    assign mf_s       = t_s64'({15'b0, r_mf});
    assign el_pos     = !r_el[63] && (r_el != '0);
    assign mres32     = mulsh_res(mul_prod, SH_TIME, r_msign);
    assign mres48     = mulsh_res(mul_prod, SH_FREQ, r_msign);
    assign mres49     = mulsh_res(mul_prod, SH_HALF, r_msign);
    assign dres       = divsh_res(div_quot, r_dneg, r_dbz, r_daz, r_daneg);
    assign lock_limit = {14'b0, r_mw} * {49'b0, LOCK_RATIO};
    assign lcur_sel   = (r_len[r_i] >= r_el) ? r_el : r_len[r_i];
    assign s1_neg     = (!r_try) != r_ho[63];
    assign s1_zero    = (r_s1 == '0);
    assign s2_ge      = (r_s2 >= r_s1);
    assign sqrt_l3    = from_mag(1'b0, sqrt_root);
    assign sqrt_l1    = r_try ? ssub(sqrt_l3, r_q) : sadd(sqrt_l3, r_q);
    assign f_calc     = ssub(sadd(r_dirfr, mres32), mf_s);
    assign f_pos      = !f_calc[63] && (f_calc != '0);
    assign lc_over    = dres > r_l1;
    assign f2_sel     = lc_over ? r_dirfr : mf_s;
    assign f2_sel_pos = !f2_sel[63] && (f2_sel != '0);
    assign f2_pos     = !r_f2[63] && (r_f2 != '0);
    assign found_dir  = r_found ? r_try : 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                case (r_op)
                    OP_QUERY:  n_state = en ? S_INT0 : S_EMIT;
                    OP_ADJUST: n_state = !en ? S_IDLE : (r_locked ? S_SH0 : S_INT0);
                    OP_CHANGE: n_state = en ? S_SH0 : S_IDLE;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_WAIT: begin
                if (!(mul_busy || div_busy || sqrt_busy)) begin
                    n_state = r_ret;
                end
            end
            S_INT0: n_state = S_INT_LOOP;
            S_INT_LOOP: begin
                if (el_pos) begin
                    n_state = S_WAIT;
                    n_ret   = S_INT_WL;
                end else begin
                    n_state = S_INT_TAIL;
                end
            end
            S_INT_WL: begin
                n_state = S_WAIT;
                n_ret   = S_INT_OFF;
            end
            S_INT_OFF: n_state = (r_i == 2'd2) ? S_INT_TAIL : S_INT_LOOP;
            S_INT_TAIL: begin
                n_state = el_pos ? S_WAIT : S_INT_END;
                n_ret   = S_INT_END;
            end
            S_INT_END: n_state = (r_op == OP_QUERY) ? S_EMIT : S_ADJ1;
            S_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            S_ADJ1: begin
                n_state = S_WAIT;
                n_ret   = S_ADJ2;
            end
            S_ADJ2: n_state = S_RB0;
            S_RB0: begin
                n_state = S_WAIT;
                n_ret   = S_RB1;
            end
            S_RB1: begin
                n_state = S_WAIT;
                n_ret   = S_RB2;
            end
            S_RB2: begin
                n_state = S_WAIT;
                n_ret   = S_RB3;
            end
            S_RB3: n_state = S_RB_TRY;
            S_RB_TRY: begin
                if (!s1_neg || s1_zero || s2_ge) begin
                    n_state = S_WAIT;
                    n_ret   = S_RB_L;
                end else if (!r_try) begin
                    n_state = S_RB_TRY;
                end else begin
                    n_state = S_RB_D;
                end
            end
            S_RB_L: begin
                if (!sqrt_l1[63] || r_try) begin
                    n_state = S_RB_D;
                end else begin
                    n_state = S_RB_TRY;
                end
            end
            S_RB_D: begin
                n_state = S_WAIT;
                n_ret   = S_RB_E;
            end
            S_RB_E: begin
                n_state = f_pos ? S_WAIT : S_RB_FIN;
                n_ret   = S_RB_G;
            end
            S_RB_G: begin
                n_state = f2_sel_pos ? S_WAIT : S_RB_H;
                n_ret   = S_RB_G2;
            end
            S_RB_G2: begin
                n_state = S_WAIT;
                n_ret   = S_RB_H;
            end
            S_RB_H:   n_state = S_RB_FIN;
            S_RB_FIN: n_state = S_SH0;
            S_SH0: begin
                n_state = S_WAIT;
                n_ret   = S_SH1;
            end
            S_SH1:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and unit control
    always_comb begin
        t_s64 v_a;
        t_s64 v_b;
        t_s64 v_t;
        v_a      = '0;
        v_b      = '0;
        v_t      = '0;
        n_mf     = r_mf;
        n_mw     = r_mw;
        n_ho     = r_ho;
        n_hf     = r_hf;
        n_lut    = r_lut;
        n_len    = r_len;
        n_dir    = r_dir;
        n_locked = r_locked;
        n_op     = r_op;
        n_now    = r_now;
        n_doff   = r_doff;
        n_dfreq  = r_dfreq;
        n_skew   = r_skew;
        n_el     = r_el;
        n_off    = r_off;
        n_fr     = r_fr;
        n_lcur   = r_lcur;
        n_wl     = r_wl;
        n_q      = r_q;
        n_l1     = r_l1;
        n_l2     = r_l2;
        n_l3     = r_l3;
        n_dirfr  = r_dirfr;
        n_f      = r_f;
        n_lc     = r_lc;
        n_f2     = r_f2;
        n_s1     = r_s1;
        n_s2     = r_s2;
        n_i      = r_i;
        n_try    = r_try;
        n_found  = r_found;
        n_rdir   = r_rdir;
        n_msign  = r_msign;
        n_dneg   = r_dneg;
        n_dbz    = r_dbz;
        n_daz    = r_daz;
        n_daneg  = r_daneg;
        n_ovalid = r_ovalid && !m_axis_tready;
        n_odata  = r_odata;
        n_oen    = r_oen;
        mul_go   = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        div_go   = 1'b0;
        div_num  = '0;
        div_den  = '0;
        sqrt_go  = 1'b0;
        sqrt_x   = '0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_op    = t_opcode'(s_axis_tuser);
                    n_now   = s_axis_tdata[63:0];
                    n_doff  = s_axis_tdata[127:64];
                    n_dfreq = {{16{s_axis_tdata[175]}}, s_axis_tdata[175:128]};
                    n_skew  = s_axis_tdata[224:176];
                end
            end
            S_DISP: begin
                case (r_op)
                    OP_QUERY: begin
                        n_off = '0;
                    end
                    OP_ADJUST: begin
                        if (en && r_locked && ({14'b0, r_skew} < lock_limit)) begin
                            n_locked = 1'b0;
                        end
                    end
                    OP_RESET: begin
                        if (en) begin
                            n_locked = 1'b1;
                            n_ho     = '0;
                            n_hf     = '0;
                            n_lut    = r_now;
                        end
                    end
                    default: begin
                        n_off = r_off;
                    end
                endcase
            end
            S_INT0: begin
                n_el  = ssub(r_now, r_lut);
                n_off = r_ho;
                n_fr  = r_hf;
                n_i   = 2'd0;
            end
            S_INT_LOOP: begin
                if (el_pos) begin
                    n_lcur  = lcur_sel;
                    mul_go  = 1'b1;
                    mul_a   = (r_i == 2'd1) ? t_u64'(0) : t_u64'(mw_s);
                    mul_b   = t_u64'(lcur_sel);
                    n_msign = (r_i == 2'd0) ? !r_dir : ((r_i == 2'd2) ? r_dir : 1'b0);
                end
            end
            S_INT_WL: begin
                n_wl    = mres32;
                v_t     = sadd(sadd(r_fr, r_fr), mres32);
                mul_go  = 1'b1;
                mul_a   = t_u64'(r_lcur);
                mul_b   = mag(v_t);
                n_msign = v_t[63];
            end
            S_INT_OFF: begin
                n_off = ssub(r_off, mres49);
                n_fr  = sadd(r_fr, r_wl);
                n_el  = r_el - r_lcur;
                n_i   = r_i + 2'd1;
            end
            S_INT_TAIL: begin
                if (el_pos) begin
                    mul_go  = 1'b1;
                    mul_a   = t_u64'(r_el);
                    mul_b   = mag(r_fr);
                    n_msign = r_fr[63];
                end
            end
            S_INT_END: begin
                if (el_pos) begin
                    n_off = ssub(r_off, mres48);
                end
            end
            S_EMIT: begin
                if (!r_ovalid || m_axis_tready) begin
                    n_ovalid = 1'b1;
                    n_odata  = r_off;
                    n_oen    = en;
                end
            end
            S_ADJ1: begin
                n_ho    = sadd(r_off, r_doff);
                n_lut   = r_now;
                v_a     = ssub(r_fr, r_dfreq);
                v_b     = ONE_FREQ - r_dfreq;
                div_go  = 1'b1;
                div_num = shl_sat(mag(v_a), SH_FREQ);
                div_den = mag(v_b);
                n_dneg  = v_a[63] != v_b[63];
                n_dbz   = (v_b == '0);
                n_daz   = (v_a == '0);
                n_daneg = v_a[63];
            end
            S_ADJ2: begin
                n_hf = dres;
            end
            S_RB0: begin
                div_go  = 1'b1;
                div_num = shl_sat(mag(r_hf), SH_TIME);
                div_den = t_u64'(mw_s);
                n_dneg  = r_hf[63];
                n_dbz   = (r_mw == '0);
                n_daz   = (r_hf == '0);
                n_daneg = r_hf[63];
            end
            S_RB1: begin
                n_q     = dres;
                div_go  = 1'b1;
                div_num = shl_sat(mag(r_ho), SH_S1);
                div_den = t_u64'(mw_s);
            end
            S_RB2: begin
                n_s1   = div_quot;
                mul_go = 1'b1;
                mul_a  = mag(r_q);
                mul_b  = mag(r_q);
            end
            S_RB3: begin
                n_s2    = mul_prod >> 1;
                n_try   = 1'b0;
                n_found = 1'b0;
                n_l1    = '0;
                n_l3    = '0;
            end
            S_RB_TRY: begin
                if (!s1_neg || s1_zero) begin
                    sqrt_go = 1'b1;
                    sqrt_x  = add_sat128(r_s2, r_s1);
                end else if (s2_ge) begin
                    sqrt_go = 1'b1;
                    sqrt_x  = r_s2 - r_s1;
                end else if (!r_try) begin
                    n_try = 1'b1;
                end
            end
            S_RB_L: begin
                n_l3    = sqrt_l3;
                n_l1    = sqrt_l1;
                n_found = !sqrt_l1[63];
                if (sqrt_l1[63] && !r_try) begin
                    n_try = 1'b1;
                end
            end
            S_RB_D: begin
                v_a     = (!r_found && r_l1[63]) ? t_s64'(0) : r_l1;
                n_l1    = v_a;
                n_l2    = '0;
                n_rdir  = found_dir;
                n_dirfr = found_dir ? r_hf : ssub(t_s64'(0), r_hf);
                mul_go  = 1'b1;
                mul_a   = t_u64'(v_a);
                mul_b   = t_u64'(mw_s);
                n_msign = 1'b0;
            end
            S_RB_E: begin
                n_f = f_calc;
                if (f_pos) begin
                    div_go  = 1'b1;
                    div_num = shl_sat(mag(f_calc), SH_TIME);
                    div_den = t_u64'(mw_s);
                    n_dneg  = 1'b0;
                    n_dbz   = (r_mw == '0);
                    n_daz   = 1'b0;
                    n_daneg = 1'b0;
                end
            end
            S_RB_G: begin
                v_a  = lc_over ? r_l1 : dres;
                n_lc = v_a;
                n_f2 = f2_sel;
                if (f2_sel_pos) begin
                    mul_go = 1'b1;
                    mul_a  = t_u64'(v_a);
                    mul_b  = t_u64'(r_f);
                end
            end
            S_RB_G2: begin
                div_go  = 1'b1;
                div_num = mul_prod;
                div_den = t_u64'(r_f2);
            end
            S_RB_H: begin
                v_a  = f2_pos ? from_mag(1'b0, u64sat(div_quot)) : S64_MAX;
                n_l2 = sadd(sadd(r_lc, r_lc), v_a);
                n_l1 = r_l1 - r_lc;
                v_t  = ssub(r_l3, r_lc);
                n_l3 = v_t[63] ? t_s64'(0) : v_t;
            end
            S_RB_FIN: begin
                n_dir    = r_rdir;
                n_len[0] = r_l1;
                n_len[1] = r_l2;
                n_len[2] = r_l3;
            end
            S_SH0: begin
                v_a     = ssub(r_now, r_lut);
                mul_go  = 1'b1;
                mul_a   = mag(v_a);
                mul_b   = mag(r_dfreq);
                n_msign = v_a[63] != r_dfreq[63];
            end
            S_SH1: begin
                n_lut = sadd(r_lut, ssub(mres48, r_doff));
            end
            default: begin
                n_off = r_off;
            end
        endcase

        if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_MAX_FREQUENCY:   n_mf = i_cfg_data;
                CFG_MAX_WANDER_RATE: n_mw = i_cfg_data;
                default:             n_mf = r_mf;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_mf     <= '0;
            r_mw     <= '0;
            r_ho     <= '0;
            r_hf     <= '0;
            r_lut    <= '0;
            r_len[0] <= '0;
            r_len[1] <= '0;
            r_len[2] <= '0;
            r_dir    <= 1'b0;
            r_locked <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_mf     <= n_mf;
            r_mw     <= n_mw;
            r_ho     <= n_ho;
            r_hf     <= n_hf;
            r_lut    <= n_lut;
            r_len[0] <= n_len[0];
            r_len[1] <= n_len[1];
            r_len[2] <= n_len[2];
            r_dir    <= n_dir;
            r_locked <= n_locked;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op    <= n_op;
        r_now   <= n_now;
        r_doff  <= n_doff;
        r_dfreq <= n_dfreq;
        r_skew  <= n_skew;
        r_el    <= n_el;
        r_off   <= n_off;
        r_fr    <= n_fr;
        r_lcur  <= n_lcur;
        r_wl    <= n_wl;
        r_q     <= n_q;
        r_l1    <= n_l1;
        r_l2    <= n_l2;
        r_l3    <= n_l3;
        r_dirfr <= n_dirfr;
        r_f     <= n_f;
        r_lc    <= n_lc;
        r_f2    <= n_f2;
        r_s1    <= n_s1;
        r_s2    <= n_s2;
        r_i     <= n_i;
        r_try   <= n_try;
        r_found <= n_found;
        r_rdir  <= n_rdir;
        r_msign <= n_msign;
        r_dneg  <= n_dneg;
        r_dbz   <= n_dbz;
        r_daz   <= n_daz;
        r_daneg <= n_daneg;
        r_odata <= n_odata;
        r_oen   <= n_oen;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_oen;

endmodule

// ===== tb/sv/clock_offset_smoother_checker.sv =====
// ----------------------------------------------------------------------------
// clock_offset_smoother_checker
// Watches the input, output and register channels of the offset smoother,
// models the wander profile in fixed point and checks every result item.
// ----------------------------------------------------------------------------
module clock_offset_smoother_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [cos_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [cos_pkg::IN_USER_W-1:0]    s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [cos_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic [cos_pkg::OUT_USER_W-1:0]   m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [cos_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [cos_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import cos_pkg::*;

    typedef struct packed {
        t_s64 offset;
        logic enabled;
    } t_offset_result;

    t_offset_result offset_results_q[$];

    t_s64 held_off, held_freq, last_time;
    t_s64 stage_len[3];
    logic ramp_up, locked;
    t_u64 lim_freq, lim_wander;

    assign o_pending = offset_results_q.size();

    function automatic t_s64 clip_add(t_s64 a, t_s64 b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic t_s64 clip_sub(t_s64 a, t_s64 b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return s[63:0];
    endfunction

    function automatic t_u64 abs_u(t_s64 a);
        return a[63] ? t_u64'(-a) : t_u64'(a);
    endfunction

    function automatic t_s64 signed_of(logic neg, t_u64 m);
        if (!neg) return m[63] ? S64_MAX : t_s64'(m);
        return m[63] ? S64_MIN : -t_s64'(m);
    endfunction

    function automatic t_u64 clip_u64(t_u128 x);
        return (|x[127:64]) ? {64{1'b1}} : x[63:0];
    endfunction

    function automatic t_u128 lift_clip(t_u64 m, int sh);
        t_u128 x;
        x = {64'b0, m};
        if (m == 0 || sh == 0) return x;
        if ((x >> (128 - sh)) != 0) return {128{1'b1}};
        return x << sh;
    endfunction

    function automatic t_u128 wide_div(t_u128 x, t_u64 d);
        if (d == 0) return {128{1'b1}};
        return x / {64'b0, d};
    endfunction

    function automatic t_s64 scaled_mul(t_s64 a, t_s64 b, int sh);
        t_u128 p;
        p = t_u128'(abs_u(a)) * t_u128'(abs_u(b));
        return signed_of(a[63] != b[63], clip_u64(p >> sh));
    endfunction

    function automatic t_s64 scaled_div(t_s64 a, t_s64 b, int sh);
        if (b == 0) return a == 0 ? t_s64'(0) : (a > 0 ? S64_MAX : S64_MIN);
        return signed_of(a[63] != b[63],
                         clip_u64(wide_div(lift_clip(abs_u(a), sh), abs_u(b))));
    endfunction

    function automatic t_u64 root_floor(t_u128 x);
        t_u64 r, t;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (x >= t_u128'(t) * t_u128'(t)) r = t;
        end
        return r;
    endfunction

    // offset and frequency of the profile carried forward to now
    function automatic void profile_at(input t_s64 now, output t_s64 off, output t_s64 fr);
        t_s64 el, mw, len, wl;
        t_s64 w[3];
        el = clip_sub(now, last_time);
        mw = t_s64'(lim_wander);
        w[0] = ramp_up ? mw : -mw;
        w[1] = 0;
        w[2] = -w[0];
        off = held_off;
        fr = held_freq;
        for (int i = 0; i < 3; i++) begin
            if (el <= 0) break;
            len = (stage_len[i] >= el) ? el : stage_len[i];
            wl = scaled_mul(w[i], len, TIME_FRAC_BITS);
            off = clip_sub(off, scaled_mul(len, clip_add(clip_add(fr, fr), wl),
                                           FREQ_FRAC_BITS + 1));
            fr = clip_add(fr, wl);
            el = el - len;
        end
        if (el > 0) off = clip_sub(off, scaled_mul(el, fr, FREQ_FRAC_BITS));
    endfunction

    function automatic void reshape_profile();
        t_s64 mw, mf, q, l1, l2, l3, dirfr, f, lc, f2, extra;
        t_u128 s1, s2, s;
        logic s1neg, neg, found, ok;
        int d;
        mw = t_s64'(lim_wander);
        mf = t_s64'(lim_freq);
        q = scaled_div(held_freq, mw, TIME_FRAC_BITS);
        s1 = wide_div(lift_clip(abs_u(held_off), TIME_FRAC_BITS + FREQ_FRAC_BITS),
                      t_u64'(mw));
        s1neg = held_off[63];
        s2 = (t_u128'(abs_u(q)) * t_u128'(abs_u(q))) >> 1;
        l1 = 0; l2 = 0; l3 = 0;
        found = 0;
        for (d = -1; d <= 1 && !found; d += 2) begin
            neg = (d < 0) != s1neg;
            ok = 1;
            if (!neg || s1 == 0) begin
                s = s1 + s2;
                if (s < s1) s = {128{1'b1}};
            end else if (s2 >= s1) begin
                s = s2 - s1;
            end else begin
                ok = 0;
            end
            if (ok) begin
                l3 = signed_of(1'b0, root_floor(s));
                l1 = (d > 0) ? clip_sub(l3, q) : clip_add(l3, q);
                if (l1 >= 0) found = 1;
            end
        end
        if (found) begin
            d -= 2;
        end else begin
            d = 1;
            if (l1 < 0) l1 = 0;
        end
        dirfr = (d > 0) ? held_freq : clip_sub(0, held_freq);
        f = clip_sub(clip_add(dirfr, scaled_mul(l1, mw, TIME_FRAC_BITS)), mf);
        if (f > 0) begin
            lc = scaled_div(f, mw, TIME_FRAC_BITS);
            f2 = mf;
            if (lc > l1) begin
                lc = l1;
                f2 = dirfr;
            end
            if (f2 <= 0) extra = S64_MAX;
            else extra = signed_of(1'b0, clip_u64(wide_div(
                    t_u128'(t_u64'(lc)) * t_u128'(t_u64'(f)), t_u64'(f2))));
            l2 = clip_add(clip_add(lc, lc), extra);
            l1 = l1 - lc;
            l3 = clip_sub(l3, lc);
            if (l3 < 0) l3 = 0;
        end
        ramp_up = (d > 0);
        stage_len[0] = l1;
        stage_len[1] = l2;
        stage_len[2] = l3;
    endfunction

    function automatic void apply_item(t_opcode op, t_s64 now, t_s64 doff,
                                       t_s64 dfreq, t_u64 skew);
        t_s64 off, fr, den, el;
        logic en;
        en = (lim_freq != 0) && (lim_wander != 0);
        if (op == OP_QUERY) begin
            off = 0;
            if (en) profile_at(now, off, fr);
            offset_results_q.push_back('{offset: off, enabled: en});
            return;
        end
        if (!en) return;
        if (op == OP_RESET) begin
            locked = 1;
            held_off = 0;
            held_freq = 0;
            last_time = now;
            return;
        end
        if (op == OP_ADJUST) begin
            if (locked) begin
                if (skew < 64'd10000 * lim_wander) locked = 0;
            end else begin
                profile_at(now, off, fr);
                held_off = clip_add(off, doff);
                den = ONE_FREQ - dfreq;
                held_freq = scaled_div(clip_sub(fr, dfreq), den, FREQ_FRAC_BITS);
                last_time = now;
                reshape_profile();
            end
        end
        el = clip_sub(now, last_time);
        last_time = clip_add(last_time,
                             clip_sub(scaled_mul(el, dfreq, FREQ_FRAC_BITS), doff));
    endfunction

    always @(posedge i_clk) begin
        t_offset_result exp_r;
        if (!i_rst_n) begin
            held_off = 0;
            held_freq = 0;
            last_time = 0;
            stage_len = '{0, 0, 0};
            ramp_up = 0;
            locked = 1;
            lim_freq = 0;
            lim_wander = 0;
            offset_results_q.delete();
            o_fail_count <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (offset_results_q.size() == 0) begin
                    $error("unexpected result item: smoothed_offset %0d",
                           $signed(m_axis_tdata));
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_r = offset_results_q.pop_front();
                    if (m_axis_tdata !== exp_r.offset) begin
                        $error("smoothed_offset: expected %0d, actual %0d",
                               exp_r.offset, $signed(m_axis_tdata));
                        o_fail_count <= o_fail_count + 1;
                    end
                    if (m_axis_tuser[0] !== exp_r.enabled) begin
                        $error("is_enabled: expected %0d, actual %0d",
                               exp_r.enabled, m_axis_tuser[0]);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_MAX_FREQUENCY) lim_freq = {15'b0, i_cfg_data};
                else lim_wander = {15'b0, i_cfg_data};
            end
            if (s_axis_tvalid && s_axis_tready) begin
                apply_item(t_opcode'(s_axis_tuser), s_axis_tdata[63:0],
                           s_axis_tdata[127:64],
                           {{16{s_axis_tdata[175]}}, s_axis_tdata[175:128]},
                           {15'b0, s_axis_tdata[224:176]});
            end
        end
    end

endmodule

// ===== tb/sv/clock_offset_smoother_core_tb.sv =====
// ----------------------------------------------------------------------------
// clock_offset_smoother_core_tb
// Drives directed and random clock events through the offset smoother over
// several limit settings, with random gaps on both streams; the checker
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module clock_offset_smoother_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cos_pkg::*;

    logic                   i_clk = 0;
    logic                   i_rst_n = 0;
    logic                   s_axis_tvalid = 0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [IN_USER_W-1:0]   s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic [OUT_USER_W-1:0]  m_axis_tuser;
    logic                   i_cfg_we = 0;
    logic [CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    int   fail_count;
    int   pending;
    logic steady = 0;
    t_s64 clock_now = 0;
    t_u64 wander_now = 0;

    always #1 i_clk = ~i_clk;

    clock_offset_smoother_core DUT (.*);

    clock_offset_smoother_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .m_axis_tuser, .i_cfg_we, .i_cfg_addr, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, 3);
        if (r < 95) return $urandom_range(4, 15);
        return $urandom_range(50, 300);
    endfunction

    function automatic t_s64 rand_s64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_s64 rand_span(int k);
        t_s64 v;
        v = rand_s64() & ((64'd1 << k) - 1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    always begin
        @(negedge i_clk);
        m_axis_tready <= 1;
        repeat ($urandom_range(1, 30)) @(negedge i_clk);
        if (!steady) begin
            m_axis_tready <= 0;
            repeat (gap_len() + 1) @(negedge i_clk);
        end
    end

    task automatic send_item(t_opcode op, t_s64 now, t_s64 doff, t_s64 dfreq,
                             logic [48:0] skew);
        int g;
        g = steady ? 0 : gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= op;
        s_axis_tdata <= {7'b0, skew, dfreq[47:0], doff, now};
        while (!s_axis_tready) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (1500) @(negedge i_clk);
        while (!s_axis_tready) @(negedge i_clk);
    endtask

    task automatic set_limits(logic [48:0] freq, logic [48:0] wander);
        settle();
        i_cfg_we <= 1;
        i_cfg_addr <= CFG_MAX_FREQUENCY;
        i_cfg_data <= freq;
        @(negedge i_clk);
        i_cfg_addr <= CFG_MAX_WANDER_RATE;
        i_cfg_data <= wander;
        @(negedge i_clk);
        i_cfg_we <= 0;
        wander_now = {15'b0, wander};
    endtask

    task automatic random_item();
        int r;
        t_opcode op;
        logic [48:0] skew;
        t_s64 now;
        if ($urandom_range(0, 99) < 85) begin
            r = $urandom_range(0, 99);
            op = r < 40 ? OP_QUERY : r < 82 ? OP_ADJUST : r < 92 ? OP_CHANGE : OP_RESET;
            now = clock_now + (rand_s64() & 64'hf_ffff_ffff);
            if ($urandom_range(0, 3) == 0) skew = 49'({$urandom, $urandom});
            else skew = 49'((64'd5000 * wander_now)
                            & ((64'd1 << $urandom_range(0, 48)) - 1));
            send_item(op, now, rand_span($urandom_range(4, 40)),
                      rand_span($urandom_range(2, 40)), skew);
            clock_now = now;
        end else begin
            send_item(t_opcode'($urandom_range(0, 3)), rand_s64(), rand_s64(),
                      rand_s64(), 49'({$urandom, $urandom}));
        end
    endtask

    initial begin
        logic [48:0] phase_freq[6];
        logic [48:0] phase_wander[6];
        phase_freq   = '{49'd140737488, 49'h1_0000_0000_0000, 49'd1,
                         49'h1_0000_0000_0000, 49'd1, 49'd0};
        phase_wander = '{49'd281475, 49'h1_0000_0000_0000, 49'd1,
                         49'd1, 49'h1_0000_0000_0000, 49'd77};
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // disabled after reset
        send_item(OP_QUERY, 64'sd1000, 0, 0, 0);
        send_item(OP_ADJUST, 64'sd2000, 64'sd5000, 0, 0);
        send_item(OP_RESET, 64'sd3000, 0, 0, 0);
        set_limits(49'd140737488000, 49'd2814750);
        send_item(OP_QUERY, 64'sd0, 0, 0, 0);
        send_item(OP_ADJUST, 64'sd4000, 64'sd10000, 0, {49{1'b1}});
        send_item(OP_ADJUST, 64'sd8000, 64'sd4294967, 64'sd1000, 0);
        send_item(OP_ADJUST, 64'h1_0000_0000, 64'sd42949672, 64'sd50000, 0);
        send_item(OP_QUERY, 64'h1_8000_0000, 0, 0, 0);
        send_item(OP_QUERY, 64'h40_0000_0000, 0, 0, 0);
        send_item(OP_ADJUST, 64'h2_0000_0000, -64'sd85899345920, -64'sd7000, 0);
        send_item(OP_QUERY, S64_MAX, 0, 0, 0);
        send_item(OP_QUERY, S64_MIN, 0, 0, 0);
        send_item(OP_CHANGE, 64'h3_0000_0000, 64'sd1000, 64'sh7fff_ffff_ffff, 0);
        send_item(OP_ADJUST, 64'h4_0000_0000, S64_MAX, 64'sh7fff_ffff_ffff, 0);
        send_item(OP_QUERY, 64'h5_0000_0000, 0, 0, 0);
        send_item(OP_ADJUST, S64_MAX, S64_MIN, -64'sh8000_0000_0000, 0);
        send_item(OP_QUERY, S64_MAX, 0, 0, 0);
        send_item(OP_CHANGE, S64_MIN, S64_MIN, -64'sh8000_0000_0000, 49'h1_0000_0000_0000);
        send_item(OP_RESET, 64'sd0, 0, 0, 0);
        send_item(OP_ADJUST, 64'sd100, 0, 0, 0);
        send_item(OP_ADJUST, 64'sd200, 0, 0, 0);
        send_item(OP_QUERY, 64'sd300, 0, 0, 0);

        for (int p = 0; p < 6; p++) begin
            set_limits(phase_freq[p], phase_wander[p]);
            clock_now = 0;
            send_item(OP_RESET, 0, 0, 0, 0);
            for (int n = 0; n < 265; n++) begin
                steady = (n >= 100 && n < 140);
                if (p == 2 && n == 150) begin
                    s_axis_tvalid <= 0;
                    while (pending != 0) @(negedge i_clk);
                end
                random_item();
            end
            steady = 0;
        end

        s_axis_tvalid <= 0;
        while (pending != 0) @(negedge i_clk);
        repeat (1500) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
